### sv/ipcm_pkg.sv
// Shared constants and types for the inverse perspective coordinate map.
package ipcm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROW0    = 3'd0;
  localparam logic [2:0] REG_ROW1    = 3'd1;
  localparam logic [2:0] REG_ROW2    = 3'd2;
  localparam logic [2:0] REG_OFFS01  = 3'd3;
  localparam logic [2:0] REG_OFFS2   = 3'd4;
  localparam logic [2:0] REG_WIDTH   = 3'd5;
  localparam logic [2:0] REG_HEIGHT  = 3'd6;

  // Fixed widths from the port definitions.
  localparam int FIELD_BITS      = 12;
  localparam int SIZE_BITS       = 13;
  localparam int COEF_BITS       = 32;
  localparam int PERSP_FRAC_BITS = 30;

  // Status flags that travel down the divider stages.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic wzero;
  } ipcm_flags_t;

endpackage

### sv/ipcm_mac.sv
// Two-stage multiply-accumulate that forms X, Y and W for one coordinate.
module ipcm_mac import ipcm_pkg::*; #(
  parameter int COORD_BITS     = 12,
  parameter int COEF_FRAC_BITS = 16,
  parameter int SW             = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_in,
  input  logic [COORD_BITS-1:0]        x,
  input  logic [COORD_BITS-1:0]        y,
  input  logic [2*COEF_BITS-1:0]       row0,
  input  logic [2*COEF_BITS-1:0]       row1,
  input  logic [2*COEF_BITS-1:0]       row2,
  input  logic [2*COEF_BITS-1:0]       offs01,
  input  logic [COEF_BITS-1:0]         offs2,
  output logic                         valid_out,
  output logic signed [SW-1:0]         bx,
  output logic signed [SW-1:0]         by,
  output logic signed [SW-1:0]         bw
);

  localparam int S  = PERSP_FRAC_BITS - COEF_FRAC_BITS;
  localparam int PW = COEF_BITS + COORD_BITS + 1;

  logic signed [COORD_BITS:0] xs, ys;
  logic signed [PW-1:0] p00_r, p01_r, p10_r, p11_r, p20_r, p21_r;
  logic signed [PW-1:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt, p20_nxt, p21_nxt;
  logic signed [COEF_BITS-1:0] h02_r, h12_r, h22_r;
  logic signed [SW-1:0] bx_r, by_r, bw_r, bx_nxt, by_nxt, bw_nxt;
  logic signed [COEF_BITS+S-1:0] h22s;
  logic v1_r, v2_r;

  assign xs = signed'({1'b0, x});
  assign ys = signed'({1'b0, y});

  // First stage: six products, one per coefficient.
  always_comb begin
    p00_nxt = PW'(signed'(row0[COEF_BITS-1:0]))           * PW'(xs);
    p01_nxt = PW'(signed'(row0[2*COEF_BITS-1:COEF_BITS])) * PW'(ys);
    p10_nxt = PW'(signed'(row1[COEF_BITS-1:0]))           * PW'(xs);
    p11_nxt = PW'(signed'(row1[2*COEF_BITS-1:COEF_BITS])) * PW'(ys);
    p20_nxt = PW'(signed'(row2[COEF_BITS-1:0]))           * PW'(xs);
    p21_nxt = PW'(signed'(row2[2*COEF_BITS-1:COEF_BITS])) * PW'(ys);
  end

  always_ff @(posedge clk) begin
    p00_r <= p00_nxt;
    p01_r <= p01_nxt;
    p10_r <= p10_nxt;
    p11_r <= p11_nxt;
    p20_r <= p20_nxt;
    p21_r <= p21_nxt;
    h02_r <= signed'(offs01[COEF_BITS-1:0]);
    h12_r <= signed'(offs01[2*COEF_BITS-1:COEF_BITS]);
    h22_r <= signed'(offs2);
  end

  // Second stage: sums; h22 is aligned to the 30-bit fraction of W.
  assign h22s = (COEF_BITS+S)'(h22_r) <<< S;

  always_comb begin
    bx_nxt = SW'(p00_r) + SW'(p01_r) + SW'(h02_r);
    by_nxt = SW'(p10_r) + SW'(p11_r) + SW'(h12_r);
    bw_nxt = SW'(p20_r) + SW'(p21_r) + SW'(h22s);
  end

  always_ff @(posedge clk) begin
    bx_r <= bx_nxt;
    by_r <= by_nxt;
    bw_r <= bw_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_in;
      v2_r <= v1_r;
    end
  end

  assign valid_out = v2_r;
  assign bx = bx_r;
  assign by = by_r;
  assign bw = bw_r;

endmodule

### sv/ipcm_div_step.sv
// One restoring-division stage that settles one quotient bit for both axes.
module ipcm_div_step import ipcm_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int SW         = 48,
  parameter int NW         = 62,
  parameter int CW         = 74,
  parameter int SHIFT      = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_in,
  input  logic [NW-1:0]         rem_x_in,
  input  logic [NW-1:0]         rem_y_in,
  input  logic [SW-1:0]         den_in,
  input  logic [COORD_BITS-1:0] q_x_in,
  input  logic [COORD_BITS-1:0] q_y_in,
  input  ipcm_flags_t           flags_in,
  output logic                  valid_out,
  output logic [NW-1:0]         rem_x_out,
  output logic [NW-1:0]         rem_y_out,
  output logic [SW-1:0]         den_out,
  output logic [COORD_BITS-1:0] q_x_out,
  output logic [COORD_BITS-1:0] q_y_out,
  output ipcm_flags_t           flags_out
);

  logic [CW-1:0] dsh;
  logic bit_x, bit_y;
  logic [NW-1:0] rem_x_nxt, rem_y_nxt, rem_x_r, rem_y_r;
  logic [COORD_BITS-1:0] q_x_r, q_y_r;
  logic [SW-1:0] den_r;
  ipcm_flags_t flags_r;
  logic valid_r;

  // Trial subtract of the shifted divisor.
  assign dsh   = CW'(den_in) << SHIFT;
  assign bit_x = CW'(rem_x_in) >= dsh;
  assign bit_y = CW'(rem_y_in) >= dsh;

  always_comb begin
    rem_x_nxt = bit_x ? NW'(CW'(rem_x_in) - dsh) : rem_x_in;
    rem_y_nxt = bit_y ? NW'(CW'(rem_y_in) - dsh) : rem_y_in;
  end

  always_ff @(posedge clk) begin
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    q_x_r   <= {q_x_in[COORD_BITS-2:0], bit_x};
    q_y_r   <= {q_y_in[COORD_BITS-2:0], bit_y};
    den_r   <= den_in;
    flags_r <= flags_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  assign valid_out = valid_r;
  assign rem_x_out = rem_x_r;
  assign rem_y_out = rem_y_r;
  assign den_out   = den_r;
  assign q_x_out   = q_x_r;
  assign q_y_out   = q_y_r;
  assign flags_out = flags_r;

endmodule

### sv/inverse_perspective_coord_map.sv
// From start to out_valid a beat passes the MAC, prepare, divider and output registers.
// Throughput: one coordinate per cycle; busy is always low.
// The depth is set by the restoring divider, one quotient bit per stage.
// Reset (synchronous, rst_n low) clears the pipeline valid bits and loads
// the identity matrix and a 4096 x 4096 frame into the configuration.
// The receiver cannot stall; each result beat is shown for one cycle.
module inverse_perspective_coord_map import ipcm_pkg::*; #(
  parameter int COORD_BITS     = 12,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [FIELD_BITS-1:0] in_out_col,
  input  logic [FIELD_BITS-1:0] in_out_row,
  output logic                  out_valid,
  output logic [FIELD_BITS-1:0] out_src_col,
  output logic [FIELD_BITS-1:0] out_src_row,
  output logic                  out_inside_res,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [2*COEF_BITS-1:0] cfg_wdata
);

  localparam int S    = PERSP_FRAC_BITS - COEF_FRAC_BITS;
  localparam int MAXB = (COORD_BITS + 1 > S) ? COORD_BITS + 1 : S;
  localparam int SW   = COEF_BITS + MAXB + 3;
  localparam int NW   = SW + S;
  localparam int CW   = SW + S + COORD_BITS;
  localparam int LW   = COORD_BITS + SIZE_BITS + 1;
  localparam int LAT  = COORD_BITS + 4;

  // Configuration registers.
  logic [2*COEF_BITS-1:0] row0_r, row1_r, row2_r, offs01_r;
  logic [COEF_BITS-1:0]   offs2_r;
  logic [SIZE_BITS-1:0]   width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r   <= 64'd65536;
      row1_r   <= 64'd65536 << 32;
      row2_r   <= '0;
      offs01_r <= '0;
      offs2_r  <= 32'd65536;
      width_r  <= 13'd4096;
      height_r <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW0:   row0_r   <= cfg_wdata;
        REG_ROW1:   row1_r   <= cfg_wdata;
        REG_ROW2:   row2_r   <= cfg_wdata;
        REG_OFFS01: offs01_r <= cfg_wdata;
        REG_OFFS2:  offs2_r  <= cfg_wdata[COEF_BITS-1:0];
        REG_WIDTH:  width_r  <= cfg_wdata[SIZE_BITS-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Input coordinates taken as their low COORD_BITS bits.
  logic [COORD_BITS+FIELD_BITS-1:0] col_ext, row_ext;
  logic [COORD_BITS-1:0] x, y;
  assign col_ext = {{COORD_BITS{1'b0}}, in_out_col};
  assign row_ext = {{COORD_BITS{1'b0}}, in_out_row};
  assign x = col_ext[COORD_BITS-1:0];
  assign y = row_ext[COORD_BITS-1:0];

  logic mac_valid;
  logic signed [SW-1:0] bx, by, bw;

  ipcm_mac #(
    .COORD_BITS(COORD_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS), .SW(SW)
  ) u_mac (
    .clk(clk), .rst_n(rst_n), .valid_in(start & ~busy), .x(x), .y(y),
    .row0(row0_r), .row1(row1_r), .row2(row2_r), .offs01(offs01_r),
    .offs2(offs2_r), .valid_out(mac_valid), .bx(bx), .by(by), .bw(bw)
  );

  // Prepare stage: magnitudes, signs, scaled numerators and saturation test.
  logic [SW-1:0] mx, my, mw;
  logic [NW-1:0] nx, ny;
  ipcm_flags_t flags_nxt;
  logic [CW-1:0] dcap;

  always_comb begin
    mx = bx[SW-1] ? SW'(-bx) : SW'(bx);
    my = by[SW-1] ? SW'(-by) : SW'(by);
    mw = bw[SW-1] ? SW'(-bw) : SW'(bw);
    nx = NW'(mx) << S;
    ny = NW'(my) << S;
    dcap = CW'(mw) << COORD_BITS;
    flags_nxt.neg_x = bx[SW-1] ^ bw[SW-1];
    flags_nxt.neg_y = by[SW-1] ^ bw[SW-1];
    flags_nxt.ovf_x = CW'(nx) >= dcap;
    flags_nxt.ovf_y = CW'(ny) >= dcap;
    flags_nxt.wzero = (bw == '0);
  end

  logic        [NW-1:0]         rem_x_s [0:COORD_BITS];
  logic        [NW-1:0]         rem_y_s [0:COORD_BITS];
  logic        [SW-1:0]         den_s   [0:COORD_BITS];
  logic        [COORD_BITS-1:0] q_x_s   [0:COORD_BITS];
  logic        [COORD_BITS-1:0] q_y_s   [0:COORD_BITS];
  ipcm_flags_t                  flg_s   [0:COORD_BITS];
  logic                         val_s   [0:COORD_BITS];

  logic [NW-1:0] prep_rx_r, prep_ry_r;
  logic [SW-1:0] prep_d_r;
  ipcm_flags_t   prep_f_r;
  logic          prep_v_r;

  always_ff @(posedge clk) begin
    prep_rx_r <= nx;
    prep_ry_r <= ny;
    prep_d_r  <= mw;
    prep_f_r  <= flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else begin
      prep_v_r <= mac_valid;
    end
  end

  assign rem_x_s[0] = prep_rx_r;
  assign rem_y_s[0] = prep_ry_r;
  assign den_s[0]   = prep_d_r;
  assign q_x_s[0]   = '0;
  assign q_y_s[0]   = '0;
  assign flg_s[0]   = prep_f_r;
  assign val_s[0]   = prep_v_r;

  // Divider chain, most significant quotient bit first.
  for (genvar k = 0; k < COORD_BITS; k++) begin : g_div
    ipcm_div_step #(
      .COORD_BITS(COORD_BITS), .SW(SW), .NW(NW), .CW(CW),
      .SHIFT(COORD_BITS - 1 - k)
    ) u_step (
      .clk(clk), .rst_n(rst_n), .valid_in(val_s[k]),
      .rem_x_in(rem_x_s[k]), .rem_y_in(rem_y_s[k]), .den_in(den_s[k]),
      .q_x_in(q_x_s[k]), .q_y_in(q_y_s[k]), .flags_in(flg_s[k]),
      .valid_out(val_s[k+1]), .rem_x_out(rem_x_s[k+1]),
      .rem_y_out(rem_y_s[k+1]), .den_out(den_s[k+1]),
      .q_x_out(q_x_s[k+1]), .q_y_out(q_y_s[k+1]), .flags_out(flg_s[k+1])
    );
  end

  // Bounds test against the frame size, saturated to the coordinate range.
  logic [COORD_BITS-1:0] qx, qy;
  ipcm_flags_t fl;
  logic [LW-1:0] cap_w;
  logic in_x, in_y, inside_nxt;
  logic [COORD_BITS+FIELD_BITS-1:0] cx_ext, cy_ext;
  logic [FIELD_BITS-1:0] col_r, row_r;
  logic inside_r, valid_r;

  assign qx = q_x_s[COORD_BITS];
  assign qy = q_y_s[COORD_BITS];
  assign fl = flg_s[COORD_BITS];
  assign cap_w = LW'(1) << COORD_BITS;

  always_comb begin
    in_x = !fl.ovf_x && !(fl.neg_x && qx != '0) &&
           ((LW'(width_r) >= cap_w) || (LW'(qx) < LW'(width_r)));
    in_y = !fl.ovf_y && !(fl.neg_y && qy != '0) &&
           ((LW'(height_r) >= cap_w) || (LW'(qy) < LW'(height_r)));
    inside_nxt = !fl.wzero && in_x && in_y;
    cx_ext = inside_nxt ? {{FIELD_BITS{1'b0}}, qx} : '0;
    cy_ext = inside_nxt ? {{FIELD_BITS{1'b0}}, qy} : '0;
  end

  always_ff @(posedge clk) begin
    col_r    <= cx_ext[FIELD_BITS-1:0];
    row_r    <= cy_ext[FIELD_BITS-1:0];
    inside_r <= inside_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= val_s[COORD_BITS];
    end
  end

  assign out_valid      = valid_r;
  assign out_src_col    = col_r;
  assign out_src_row    = row_r;
  assign out_inside_res = inside_r;

`ifndef NO_ASSERTIONS
  // An outside result carries zero coordinates.
  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_inside_res) |-> (out_src_col == '0 && out_src_row == '0))
    else $error("outside result with nonzero coordinates");

  // Every accepted beat comes out after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("result beat missing after pipeline latency");
`endif

endmodule
